// ----- rtl/core/glitch_pulse_sequencer_macros.svh -----
// Assertion macros shared by the glitch pulse sequencer RTL.
`ifndef GLITCH_PULSE_SEQUENCER_MACROS_SVH
`define GLITCH_PULSE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/gps_pkg.sv -----
// Types, codes and constants of the glitch pulse sequencer.
package gps_pkg;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int COUNT_W     = 32;
   localparam int MARKER_TICKS = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_DELAY       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_TIMEOUT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PING_TIMEOUT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCCESS_TIMEOUT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTORE_MASK    = 3'd7;

   localparam int MASK_CORE_BIT = 0;
   localparam int MASK_SOC_BIT  = 1;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ARM      = 2'd1;
   localparam logic [1:0] OP_START    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ST_PENDING = 2'd0;
   localparam logic [1:0] ST_OK      = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_PULSE = 2'd1;
   localparam logic [1:0] REQ_SOC   = 2'd2;
   localparam logic [1:0] REQ_CORE  = 2'd3;

   localparam logic [1:0] RES_RUNNING    = 2'd0;
   localparam logic [1:0] RES_BROKEN     = 2'd1;
   localparam logic [1:0] RES_SUCCESS    = 2'd2;
   localparam logic [1:0] RES_SEND_ERROR = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE          = 5'd0,
      PH_SELWAIT       = 5'd1,
      PH_PRE           = 5'd2,
      PH_SEND_PULSE    = 5'd3,
      PH_HOLD          = 5'd4,
      PH_SEND_SOC      = 5'd5,
      PH_SEND_CORE     = 5'd6,
      PH_COOL          = 5'd7,
      PH_ERR_CORE      = 5'd8,
      PH_ERR_SOC       = 5'd9,
      PH_ERR_CORE_LAST = 5'd10,
      PH_PING_WAIT     = 5'd11,
      PH_PING_LOW      = 5'd12,
      PH_SUCCESS_WAIT  = 5'd13,
      PH_MARK_BROKEN   = 5'd14,
      PH_MARK_RUNNING  = 5'd15,
      PH_MARK_SUCCESS  = 5'd16
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       select_low;
      logic [1:0] send_status;
   } req_type;

   typedef struct packed {
      logic       trigger_level;
      logic [1:0] send_request;
      logic       broken_marker;
      logic       running_marker;
      logic       success_marker;
      logic       result_valid;
      logic [1:0] result_code;
      logic       select_was_low;
      logic       busy_res;
   } rsp_type;

endpackage

// ----- rtl/core/gps_stream_if.sv -----
// Valid/ready stream interface that carries one payload per beat.
interface gps_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/glitch_pulse_sequencer.sv -----
// Top level of the tick-driven glitch pulse sequencer.
//
//   channel   | direction | payload                 | beat taken when
//   ----------+-----------+-------------------------+------------------------
//   req_chan  | in        | gps_pkg::req_type       | valid && ready
//   rsp_chan  | out       | gps_pkg::rsp_type       | valid && ready
//   csr_*     | in        | index, 32-bit data      | csr_wr_en
//
// Each req beat is one tick and yields exactly one rsp beat, from the result register, in the cycle after it is taken.
// The phase update and the result are computed combinationally into the result
// register, so a new beat is taken every cycle while rsp is drained.
// req_chan.ready drops only while a result is held and rsp_chan.ready is low.
// Reset is synchronous and restores every register except rsp_data_ff to its documented value.
`include "glitch_pulse_sequencer_macros.svh"

module glitch_pulse_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   gps_stream_if.sink                         req_chan,
   gps_stream_if.source                       rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [gps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import gps_pkg::*;

   logic [COUNT_W-1:0] pre_delay_ff, pulse_ticks_ff, cooldown_ticks_ff, repeat_count_ff;
   logic [COUNT_W-1:0] select_timeout_ff, ping_timeout_ff, success_timeout_ff;
   logic [1:0]         restore_mask_ff;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] tick_ff, tick_in;
   logic [COUNT_W-1:0] repeats_ff, repeats_in;
   logic               armed_ff, armed_in;
   logic               sel_flag_ff, sel_flag_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   req_type            req;
   logic               req_accept;
   logic               st_ok, st_bad, restore_core, restore_soc;
   logic               tick_zero, timed_done;
   logic [COUNT_W-1:0] tick_dec, pre_load, marker_load;
   phase_type          repeat_phase;
   logic [COUNT_W-1:0] repeat_ticks;
   logic               res_valid;
   logic [1:0]         res_code;
   logic               trig;
   logic [1:0]         send_req;

   assign req          = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept   = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_delay_ff       <= '0;
         pulse_ticks_ff     <= '0;
         cooldown_ticks_ff  <= '0;
         repeat_count_ff    <= COUNT_W'(1);
         select_timeout_ff  <= '0;
         ping_timeout_ff    <= '0;
         success_timeout_ff <= '0;
         restore_mask_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRE_DELAY:       pre_delay_ff       <= csr_wr_data;
            CSR_PULSE_TICKS:     pulse_ticks_ff     <= csr_wr_data;
            CSR_COOLDOWN_TICKS:  cooldown_ticks_ff  <= csr_wr_data;
            CSR_REPEAT_COUNT:    repeat_count_ff    <= csr_wr_data;
            CSR_SELECT_TIMEOUT:  select_timeout_ff  <= csr_wr_data;
            CSR_PING_TIMEOUT:    ping_timeout_ff    <= csr_wr_data;
            CSR_SUCCESS_TIMEOUT: success_timeout_ff <= csr_wr_data;
            CSR_RESTORE_MASK:    restore_mask_ff    <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         repeats_ff  <= '0;
         armed_ff    <= 1'b0;
         sel_flag_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         repeats_ff  <= repeats_in;
         armed_ff    <= armed_in;
         sel_flag_ff <= sel_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign st_ok        = (req.send_status == ST_OK);
   assign st_bad       = (req.send_status inside {ST_FAILED, ST_INVALID});
   assign restore_core = restore_mask_ff[MASK_CORE_BIT];
   assign restore_soc  = restore_mask_ff[MASK_SOC_BIT];
   assign tick_zero    = (tick_ff == '0);
   assign tick_dec     = tick_ff - COUNT_W'(1);
   assign timed_done   = (tick_ff <= COUNT_W'(1));
   assign pre_load     = (pulse_ticks_ff <= pre_delay_ff) ? (pre_delay_ff - pulse_ticks_ff) : '0;
   assign marker_load  = COUNT_W'(MARKER_TICKS - 1);
   assign repeat_phase = (repeats_ff < repeat_count_ff) ? PH_SEND_PULSE : PH_PING_WAIT;
   assign repeat_ticks = (repeats_ff < repeat_count_ff) ? '0 : ping_timeout_ff;

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      repeats_in  = repeats_ff;
      armed_in    = armed_ff;
      sel_flag_in = sel_flag_ff;
      res_valid   = 1'b0;
      res_code    = RES_RUNNING;

      case (phase_ff)
         PH_IDLE: begin
            if (req.operation == OP_START) begin
               repeats_in = '0;
               phase_in   = PH_PRE;
               tick_in    = pre_load;
            end else if (req.operation == OP_ARM) begin
               armed_in = 1'b1;
            end else if (armed_ff && req.select_low) begin
               phase_in = PH_SELWAIT;
               tick_in  = select_timeout_ff;
            end
         end
         PH_SELWAIT: begin
            if (tick_zero) begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end else if (req.select_low) begin
               tick_in = tick_dec;
            end else begin
               armed_in   = 1'b0;
               repeats_in = '0;
               phase_in   = PH_PRE;
               tick_in    = pre_load;
            end
         end
         PH_PRE, PH_COOL: begin
            if (timed_done) begin
               phase_in = repeat_phase;
               tick_in  = repeat_ticks;
            end else begin
               tick_in = tick_dec;
            end
         end
         PH_SEND_PULSE: begin
            if (st_ok) begin
               phase_in = PH_HOLD;
               tick_in  = pulse_ticks_ff;
            end else if (st_bad) begin
               if (restore_core) begin
                  phase_in = PH_ERR_CORE;
                  tick_in  = '0;
               end else if (restore_soc) begin
                  phase_in = PH_ERR_SOC;
                  tick_in  = '0;
               end else begin
                  phase_in  = PH_IDLE;
                  tick_in   = '0;
                  res_valid = 1'b1;
                  res_code  = RES_SEND_ERROR;
               end
            end
         end
         PH_HOLD: begin
            if (timed_done) begin
               if (restore_soc) begin
                  phase_in = PH_SEND_SOC;
                  tick_in  = '0;
               end else if (restore_core) begin
                  phase_in = PH_SEND_CORE;
                  tick_in  = '0;
               end else begin
                  sel_flag_in = req.select_low;
                  repeats_in  = repeats_ff + COUNT_W'(1);
                  phase_in    = PH_COOL;
                  tick_in     = cooldown_ticks_ff;
               end
            end else begin
               tick_in = tick_dec;
            end
         end
         PH_SEND_SOC: begin
            if (st_ok) begin
               if (restore_core) begin
                  phase_in = PH_SEND_CORE;
                  tick_in  = '0;
               end else begin
                  sel_flag_in = req.select_low;
                  repeats_in  = repeats_ff + COUNT_W'(1);
                  phase_in    = PH_COOL;
                  tick_in     = cooldown_ticks_ff;
               end
            end else if (st_bad) begin
               if (restore_core) begin
                  phase_in = PH_ERR_CORE_LAST;
                  tick_in  = '0;
               end else begin
                  phase_in  = PH_IDLE;
                  tick_in   = '0;
                  res_valid = 1'b1;
                  res_code  = RES_SEND_ERROR;
               end
            end
         end
         PH_SEND_CORE: begin
            if (st_ok) begin
               sel_flag_in = req.select_low;
               repeats_in  = repeats_ff + COUNT_W'(1);
               phase_in    = PH_COOL;
               tick_in     = cooldown_ticks_ff;
            end else if (st_bad) begin
               phase_in  = PH_IDLE;
               tick_in   = '0;
               res_valid = 1'b1;
               res_code  = RES_SEND_ERROR;
            end
         end
         PH_ERR_CORE: begin
            if (req.send_status != ST_PENDING) begin
               if (restore_soc) begin
                  phase_in = PH_ERR_SOC;
                  tick_in  = '0;
               end else begin
                  phase_in  = PH_IDLE;
                  tick_in   = '0;
                  res_valid = 1'b1;
                  res_code  = RES_SEND_ERROR;
               end
            end
         end
         PH_ERR_SOC, PH_ERR_CORE_LAST: begin
            if (req.send_status != ST_PENDING) begin
               phase_in  = PH_IDLE;
               tick_in   = '0;
               res_valid = 1'b1;
               res_code  = RES_SEND_ERROR;
            end
         end
         PH_PING_WAIT: begin
            if (tick_zero) begin
               phase_in = PH_MARK_BROKEN;
               tick_in  = marker_load;
            end else if (req.select_low) begin
               phase_in = PH_PING_LOW;
               tick_in  = select_timeout_ff;
            end else begin
               tick_in = tick_dec;
            end
         end
         PH_PING_LOW: begin
            if (tick_zero) begin
               phase_in = PH_MARK_BROKEN;
               tick_in  = marker_load;
            end else if (!req.select_low) begin
               phase_in = PH_SUCCESS_WAIT;
               tick_in  = success_timeout_ff;
            end else begin
               tick_in = tick_dec;
            end
         end
         PH_SUCCESS_WAIT: begin
            if (tick_zero) begin
               phase_in = PH_MARK_RUNNING;
               tick_in  = marker_load;
            end else if (req.select_low) begin
               phase_in = PH_MARK_SUCCESS;
               tick_in  = marker_load;
            end else begin
               tick_in = tick_dec;
            end
         end
         PH_MARK_BROKEN, PH_MARK_RUNNING, PH_MARK_SUCCESS: begin
            if (!tick_zero) begin
               tick_in = tick_dec;
            end else begin
               phase_in  = PH_IDLE;
               tick_in   = '0;
               res_valid = 1'b1;
               if (phase_ff == PH_MARK_BROKEN) begin
                  res_code = RES_BROKEN;
               end else if (phase_ff == PH_MARK_RUNNING) begin
                  res_code = RES_RUNNING;
               end else begin
                  res_code = RES_SUCCESS;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase

      trig     = 1'b0;
      send_req = REQ_NONE;
      case (phase_in)
         PH_PRE, PH_HOLD: begin
            trig = 1'b1;
         end
         PH_SEND_PULSE: begin
            trig     = 1'b1;
            send_req = REQ_PULSE;
         end
         PH_SEND_SOC, PH_ERR_SOC: begin
            trig     = 1'b1;
            send_req = REQ_SOC;
         end
         PH_SEND_CORE, PH_ERR_CORE, PH_ERR_CORE_LAST: begin
            trig     = 1'b1;
            send_req = REQ_CORE;
         end
         default: ;
      endcase

      rsp_data_in.trigger_level  = trig;
      rsp_data_in.send_request   = send_req;
      rsp_data_in.broken_marker  = (phase_in == PH_MARK_BROKEN);
      rsp_data_in.running_marker = (phase_in == PH_MARK_RUNNING);
      rsp_data_in.success_marker = (phase_in == PH_MARK_SUCCESS);
      rsp_data_in.result_valid   = res_valid;
      rsp_data_in.result_code    = res_code;
      rsp_data_in.select_was_low = sel_flag_in;
      rsp_data_in.busy_res       = (phase_in != PH_IDLE);
   end

   `GPS_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_chan.ready, "req_chan not ready while the result register is empty")
   `GPS_ASSERT_NOW(a_result_quiet, clock, reset, rsp_valid_ff && rsp_data_ff.result_valid, !rsp_data_ff.trigger_level && !rsp_data_ff.busy_res && !rsp_data_ff.broken_marker && !rsp_data_ff.running_marker && !rsp_data_ff.success_marker, "result beat shows trigger, busy or marker")
   `GPS_ASSERT_NOW(a_marker_bound, clock, reset, phase_ff == PH_MARK_BROKEN || phase_ff == PH_MARK_RUNNING || phase_ff == PH_MARK_SUCCESS, tick_ff < COUNT_W'(MARKER_TICKS), "marker counter out of range")
   `GPS_ASSERT_NEXT(a_busy_tracks_phase, clock, reset, req_accept, rsp_data_ff.busy_res == (phase_ff != PH_IDLE), "busy_res disagrees with the phase register")
   `GPS_ASSERT_NEXT(a_manual_start, clock, reset, req_accept && phase_ff == PH_IDLE && req.operation == OP_START, phase_ff == PH_PRE, "manual start did not enter the pre-delay")

endmodule

// ----- tb/sv/glitch_pulse_sequencer_checker.sv -----
// Beat monitor, sequencer prediction and result comparison for the glitch pulse sequencer.
module glitch_pulse_sequencer_checker
   import gps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     mismatch_count,
   output int                     awaited_count,
   output logic                   seq_idle,
   output int                     beats_checked,
   output int                     ends_running,
   output int                     ends_broken,
   output int                     ends_success,
   output int                     ends_error
);

   logic [31:0] cfg_pre, cfg_pulse, cfg_cool, cfg_repeat;
   logic [31:0] cfg_sel_to, cfg_ping_to, cfg_succ_to;
   logic [1:0]  cfg_mask;

   phase_type   phase;
   logic [31:0] ticks_left;
   logic [31:0] pulses_done;
   logic        armed;
   logic        sel_flag;
   logic        run_done;
   logic [1:0]  run_code;

   rsp_type     expected_rsp[$];
   rsp_type     want;
   int          n_mismatch;
   int          n_beats;
   int          n_ends[4];

   task automatic report_mismatch(input string msg);
      n_mismatch++;
      $display("mismatch at result beat %0d: %s", n_beats, msg);
   endtask

   task automatic compare_field(input string name, input logic [1:0] got,
                                input logic [1:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
   endtask

   function automatic void enter_phase(input phase_type p, input logic [31:0] n);
      phase = p;
      ticks_left = n;
   endfunction

   function automatic void end_run(input logic [1:0] code);
      enter_phase(PH_IDLE, 0);
      run_done = 1'b1;
      run_code = code;
   endfunction

   function automatic void launch_run();
      pulses_done = 0;
      enter_phase(PH_PRE, (cfg_pulse <= cfg_pre) ? cfg_pre - cfg_pulse : 32'd0);
   endfunction

   function automatic void next_pulse();
      if (pulses_done < cfg_repeat)
         enter_phase(PH_SEND_PULSE, 0);
      else
         enter_phase(PH_PING_WAIT, cfg_ping_to);
   endfunction

   function automatic void close_pulse(input logic sl);
      sel_flag = sl;
      pulses_done = pulses_done + 1;
      enter_phase(PH_COOL, cfg_cool);
   endfunction

   function automatic logic count_down();
      if (ticks_left != 0)
         ticks_left = ticks_left - 1;
      return ticks_left == 0;
   endfunction

   // Advances the sequencer by one tick and returns the result beat it produces.
   function automatic rsp_type advance(input req_type r);
      rsp_type     o;
      logic        ok, bad, core, soc, sl;
      logic [31:0] marker_last;
      ok = (r.send_status == ST_OK);
      bad = (r.send_status == ST_FAILED) || (r.send_status == ST_INVALID);
      core = cfg_mask[MASK_CORE_BIT];
      soc = cfg_mask[MASK_SOC_BIT];
      sl = r.select_low;
      marker_last = 32'(MARKER_TICKS - 1);
      run_done = 1'b0;
      run_code = RES_RUNNING;
      case (phase)
         PH_IDLE: begin
            if (r.operation == OP_START) launch_run();
            else if (r.operation == OP_ARM) armed = 1'b1;
            else if (armed && sl) enter_phase(PH_SELWAIT, cfg_sel_to);
         end
         PH_SELWAIT: begin
            if (ticks_left == 0) enter_phase(PH_IDLE, 0);
            else if (sl) ticks_left = ticks_left - 1;
            else begin
               armed = 1'b0;
               launch_run();
            end
         end
         PH_PRE, PH_COOL: begin
            if (count_down()) next_pulse();
         end
         PH_SEND_PULSE: begin
            if (ok) enter_phase(PH_HOLD, cfg_pulse);
            else if (bad) begin
               if (core) enter_phase(PH_ERR_CORE, 0);
               else if (soc) enter_phase(PH_ERR_SOC, 0);
               else end_run(RES_SEND_ERROR);
            end
         end
         PH_HOLD: begin
            if (count_down()) begin
               if (soc) enter_phase(PH_SEND_SOC, 0);
               else if (core) enter_phase(PH_SEND_CORE, 0);
               else close_pulse(sl);
            end
         end
         PH_SEND_SOC: begin
            if (ok) begin
               if (core) enter_phase(PH_SEND_CORE, 0);
               else close_pulse(sl);
            end else if (bad) begin
               if (core) enter_phase(PH_ERR_CORE_LAST, 0);
               else end_run(RES_SEND_ERROR);
            end
         end
         PH_SEND_CORE: begin
            if (ok) close_pulse(sl);
            else if (bad) end_run(RES_SEND_ERROR);
         end
         PH_ERR_CORE: begin
            if (r.send_status != ST_PENDING) begin
               if (soc) enter_phase(PH_ERR_SOC, 0);
               else end_run(RES_SEND_ERROR);
            end
         end
         PH_ERR_SOC, PH_ERR_CORE_LAST: begin
            if (r.send_status != ST_PENDING) end_run(RES_SEND_ERROR);
         end
         PH_PING_WAIT: begin
            if (ticks_left == 0) enter_phase(PH_MARK_BROKEN, marker_last);
            else if (sl) enter_phase(PH_PING_LOW, cfg_sel_to);
            else ticks_left = ticks_left - 1;
         end
         PH_PING_LOW: begin
            if (ticks_left == 0) enter_phase(PH_MARK_BROKEN, marker_last);
            else if (!sl) enter_phase(PH_SUCCESS_WAIT, cfg_succ_to);
            else ticks_left = ticks_left - 1;
         end
         PH_SUCCESS_WAIT: begin
            if (ticks_left == 0) enter_phase(PH_MARK_RUNNING, marker_last);
            else if (sl) enter_phase(PH_MARK_SUCCESS, marker_last);
            else ticks_left = ticks_left - 1;
         end
         PH_MARK_BROKEN, PH_MARK_RUNNING, PH_MARK_SUCCESS: begin
            if (ticks_left != 0) ticks_left = ticks_left - 1;
            else if (phase == PH_MARK_BROKEN) end_run(RES_BROKEN);
            else if (phase == PH_MARK_RUNNING) end_run(RES_RUNNING);
            else end_run(RES_SUCCESS);
         end
         default: begin
            enter_phase(PH_IDLE, 0);
         end
      endcase

      o = '0;
      o.send_request = REQ_NONE;
      case (phase)
         PH_PRE, PH_HOLD: begin
            o.trigger_level = 1'b1;
         end
         PH_SEND_PULSE: begin
            o.trigger_level = 1'b1;
            o.send_request = REQ_PULSE;
         end
         PH_SEND_SOC, PH_ERR_SOC: begin
            o.trigger_level = 1'b1;
            o.send_request = REQ_SOC;
         end
         PH_SEND_CORE, PH_ERR_CORE, PH_ERR_CORE_LAST: begin
            o.trigger_level = 1'b1;
            o.send_request = REQ_CORE;
         end
         default: ;
      endcase
      o.broken_marker = (phase == PH_MARK_BROKEN);
      o.running_marker = (phase == PH_MARK_RUNNING);
      o.success_marker = (phase == PH_MARK_SUCCESS);
      o.result_valid = run_done;
      o.result_code = run_code;
      o.select_was_low = sel_flag;
      o.busy_res = (phase != PH_IDLE);
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_pre = 0;
         cfg_pulse = 0;
         cfg_cool = 0;
         cfg_repeat = 1;
         cfg_sel_to = 0;
         cfg_ping_to = 0;
         cfg_succ_to = 0;
         cfg_mask = '0;
         phase = PH_IDLE;
         ticks_left = 0;
         pulses_done = 0;
         armed = 1'b0;
         sel_flag = 1'b0;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRE_DELAY:       cfg_pre = csr_wr_data;
               CSR_PULSE_TICKS:     cfg_pulse = csr_wr_data;
               CSR_COOLDOWN_TICKS:  cfg_cool = csr_wr_data;
               CSR_REPEAT_COUNT:    cfg_repeat = csr_wr_data;
               CSR_SELECT_TIMEOUT:  cfg_sel_to = csr_wr_data;
               CSR_PING_TIMEOUT:    cfg_ping_to = csr_wr_data;
               CSR_SUCCESS_TIMEOUT: cfg_succ_to = csr_wr_data;
               CSR_RESTORE_MASK:    cfg_mask = csr_wr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            n_beats++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("result beat arrived with no request outstanding");
            end else begin
               want = expected_rsp.pop_front();
               compare_field("trigger_level", 2'(rsp_payload.trigger_level),
                             2'(want.trigger_level));
               compare_field("send_request", rsp_payload.send_request, want.send_request);
               compare_field("broken_marker", 2'(rsp_payload.broken_marker),
                             2'(want.broken_marker));
               compare_field("running_marker", 2'(rsp_payload.running_marker),
                             2'(want.running_marker));
               compare_field("success_marker", 2'(rsp_payload.success_marker),
                             2'(want.success_marker));
               compare_field("result_valid", 2'(rsp_payload.result_valid),
                             2'(want.result_valid));
               compare_field("result_code", rsp_payload.result_code, want.result_code);
               compare_field("select_was_low", 2'(rsp_payload.select_was_low),
                             2'(want.select_was_low));
               compare_field("busy_res", 2'(rsp_payload.busy_res), 2'(want.busy_res));
            end
         end
         if (req_valid && req_ready) begin
            want = advance(req_payload);
            if (want.result_valid)
               n_ends[want.result_code]++;
            expected_rsp.push_back(want);
         end
      end
      mismatch_count <= n_mismatch;
      awaited_count <= expected_rsp.size();
      seq_idle <= (phase == PH_IDLE);
      beats_checked <= n_beats;
      ends_running <= n_ends[RES_RUNNING];
      ends_broken <= n_ends[RES_BROKEN];
      ends_success <= n_ends[RES_SUCCESS];
      ends_error <= n_ends[RES_SEND_ERROR];
   end

endmodule

// ----- tb/sv/glitch_pulse_sequencer_tb.sv -----
// Top of the glitch pulse sequencer testbench: clock, reset, stimulus and verdict.
module glitch_pulse_sequencer_tb;
   import gps_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 200;
   localparam int SETTING_SETS = 8;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   gps_stream_if #(.payload_type(req_type)) req_if ();
   gps_stream_if #(.payload_type(rsp_type)) rsp_if ();

   int   mismatch_count;
   int   awaited_count;
   logic seq_idle;
   int   beats_checked;
   int   ends_running, ends_broken, ends_success, ends_error;

   bit   calm;
   bit   sl_level;
   int   cycles;
   int   settings_used;

   glitch_pulse_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   glitch_pulse_sequencer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_payload    (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_payload    (rsp_if.payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .seq_idle       (seq_idle),
      .beats_checked  (beats_checked),
      .ends_running   (ends_running),
      .ends_broken    (ends_broken),
      .ends_success   (ends_success),
      .ends_error     (ends_error)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 18);
   end

   function automatic req_type tick_beat(input logic [1:0] op, input logic sl,
                                         input logic [1:0] st);
      req_type b;
      b.operation = op;
      b.select_low = sl;
      b.send_status = st;
      return b;
   endfunction

   // Mostly plain ticks, with chip select held in runs so that both edges of
   // every watch window occur, and sender replies that usually succeed.
   function automatic req_type random_beat();
      int          r_op, r_st;
      logic [1:0]  op, st;
      r_op = $urandom_range(0, 99);
      r_st = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 30)
         sl_level = ~sl_level;
      if (r_op < 85) op = OP_TICK;
      else if (r_op < 91) op = OP_ARM;
      else if (r_op < 96) op = OP_START;
      else op = OP_RESERVED;
      if (r_st < 45) st = ST_PENDING;
      else if (r_st < 85) st = ST_OK;
      else if (r_st < 93) st = ST_FAILED;
      else st = ST_INVALID;
      return tick_beat(op, sl_level, st);
   endfunction

   task automatic send_beat(input req_type b);
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // Feeds plain ticks until the sequencer is back in idle with nothing outstanding.
   task automatic settle();
      bit done = 1'b0;
      while (!done) begin
         wait_for_results();
         if (seq_idle) begin
            done = 1'b1;
         end else begin
            do send_beat(tick_beat(OP_TICK, 1'($urandom_range(0, 1)),
                                   2'($urandom_range(0, 3))));
            while (!seq_idle);
         end
      end
   endtask

   task automatic apply_settings(input logic [31:0] pre, pulse, cool, reps,
                                 input logic [31:0] sel_to, ping_to, succ_to, mask);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [31:0]            data [8];
      idx = '{CSR_PRE_DELAY, CSR_PULSE_TICKS, CSR_COOLDOWN_TICKS, CSR_REPEAT_COUNT,
              CSR_SELECT_TIMEOUT, CSR_PING_TIMEOUT, CSR_SUCCESS_TIMEOUT, CSR_RESTORE_MASK};
      data = '{pre, pulse, cool, reps, sel_to, ping_to, succ_to, mask};
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wr_data <= data[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_PRE_DELAY;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      calm = 1'b0;
      sl_level = 1'b0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_beat(tick_beat(OP_ARM, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b1, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_RESERVED, 1'b1, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b1, ST_OK));
      send_beat(tick_beat(OP_START, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_ARM, 1'b1, ST_OK));
      send_beat(tick_beat(OP_TICK, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_RESERVED, 1'b1, ST_INVALID));
      send_beat(tick_beat(OP_START, 1'b1, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b0, ST_OK));
      send_beat(tick_beat(OP_TICK, 1'b1, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b0, ST_PENDING));
      send_beat(tick_beat(OP_TICK, 1'b1, ST_FAILED));
      repeat (10) send_beat(tick_beat(OP_TICK, 1'b0, ST_PENDING));
      settle();

      for (int p = 0; p < SETTING_SETS; p++) begin
         case (p)
            1: apply_settings(0, 0, 0, 0, 0, 0, 0, 3);
            2: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: apply_settings(2, 3, 1, 32'hFFFF_FFFF, 4, 6, 6, 3);
            default: apply_settings($urandom_range(0, 6), $urandom_range(0, 4),
                                    $urandom_range(0, 4), $urandom_range(0, 3),
                                    $urandom_range(0, 6), $urandom_range(0, 8),
                                    $urandom_range(0, 8), $urandom());
         endcase
         calm = (p == 5);
         for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (p == 4 && n == RANDOM_BEATS / 2)
               wait_for_results();
            send_beat(random_beat());
         end
         settle();
      end

      calm = 1'b0;
      repeat (4) @(posedge clock);
      $display("Checked %0d result beats under %0d register settings.",
               beats_checked, settings_used);
      $display("Runs ended: %0d running, %0d broken, %0d success, %0d send error.",
               ends_running, ends_broken, ends_success, ends_error);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
